// File: rtl/rbf_pkg.sv
// Shared types, widths and constants of the Gaussian RBF kernel evaluator.
`timescale 1ns / 1ps

package rbf_pkg;

   // Field widths
   localparam int COORD_W   = 16;
   localparam int INV_W     = 24;
   localparam int KV_W      = 17;

   // Datapath widths
   localparam int DIFF_W    = COORD_W + 1;          // x - y, signed Q9.8
   localparam int SQ_W      = 32;                   // d * d, Q16.16
   localparam int SUM_W     = 38;                   // accumulated sum, Q22.16
   localparam int HALF_W    = SUM_W / 2;            // split point for the scale multiply
   localparam int PP_W      = HALF_W + INV_W;       // one partial product
   localparam int PROD_W    = SUM_W + INV_W;        // full scaled sum
   localparam int A_W       = PROD_W - 1;           // exponent after halving, Q.32
   localparam int F_W       = 32;                   // fractional part of the exponent
   localparam int K_W       = 5;                    // integer part, 0 to 24
   localparam int TERM_W    = 31;                   // Q1.30 series values
   localparam int DQ_W      = 30;                   // dividend / quotient of one term
   localparam int RECIP_W   = 35;                   // reciprocal of the term index
   localparam int RECIP_SHIFT = 34;                 // reciprocal scale, 2^34
   localparam int TIDX_W    = 5;

   // Sequencing
   localparam int TAYLOR_TERMS       = 16;

   // Constants
   localparam logic [INV_W-1:0]  INV_RESET = 24'd65536;        // 1.0 in Q8.16
   localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [K_W-1:0]    K_LIMIT   = 5'd24;
   localparam logic [A_W-1:0]    EXP_LIMIT = A_W'(24) << F_W;  // 24.0 in Q.32
   localparam logic [TERM_W-1:0] ONE_Q30   = TERM_W'(1) << 30;
   localparam logic [28:0]       EINV_Q30  = 29'd395007542;    // e^-1 in Q1.30
   localparam logic [60:0]       HALF_Q30  = 61'(1) << 29;
   localparam logic [31:0]       HALF_Q16  = 32'(1) << 13;

   // Channel payloads
   typedef struct packed {
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
      logic                      last_pair;
   } rbf_req_type;

   typedef struct packed {
      logic [KV_W-1:0] kernel_value;
      logic            exponent_saturated;
   } rbf_rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic              load_pair;
      logic              square;
      logic              accum;
      logic              prod_lo;
      logic              prod_hi;
      logic              exponent;
      logic              term_mul;
      logic              div_step;
      logic              term_add;
      logic              einv_step;
      logic              rsp_load;
      logic [TIDX_W-1:0] term_idx;
   } rbf_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic last_pair;
      logic k_zero;
   } rbf_sts_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_PROD_LO,
      ST_PROD_HI,
      ST_EXPONENT,
      ST_TERM_MUL,
      ST_TERM_DIV,
      ST_TERM_ADD,
      ST_EINV,
      ST_FINISH
   } rbf_state_type;

endpackage

// File: rtl/rbf_datapath.sv
// Datapath: accumulator, scale multiply, Taylor series with term divider, e^-1 steps.
`timescale 1ns / 1ps

module rbf_datapath
   import rbf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  rbf_req_type         req_data,
   input  logic                csr_valid,
   input  logic [INV_W-1:0]    csr_data,
   input  rbf_cmd_type         cmd,
   output rbf_sts_type         sts,
   output rbf_rsp_type         rsp_data
);

   // Registers with reset
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [INV_W-1:0]   inv_ff, inv_in;

   // Payload registers
   logic signed [DIFF_W-1:0] d_ff, d_in;
   logic                last_ff, last_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic [PP_W-1:0]     p_lo_ff, p_lo_in;
   logic [PP_W-1:0]     p_hi_ff, p_hi_in;
   logic [K_W-1:0]      k_ff, k_in;
   logic [F_W-1:0]      f_ff, f_in;
   logic                sat_ff, sat_in;
   logic [TERM_W-1:0]   term_ff, term_in;
   logic [TERM_W-1:0]   tsum_ff, tsum_in;
   logic [DQ_W-1:0]     dq_ff, dq_in;
   logic [KV_W-1:0]     kv_ff, kv_in;
   logic                rsat_ff, rsat_in;

   // Arithmetic intermediates
   logic signed [2*DIFF_W-1:0] sq_full;
   logic [SUM_W:0]      acc_sum;
   logic [PROD_W-1:0]   prod_full;
   logic [A_W-1:0]      a_val;
   logic                a_sat;
   logic [TERM_W+F_W-1:0] term_prod;
   logic [59:0]         einv_prod;
   logic [60:0]         einv_round;
   logic [31:0]         kv_round;
   logic [RECIP_W-1:0]  recip;
   logic [DQ_W+RECIP_W-1:0] div_prod;

   // Square of the difference and saturating accumulate
   assign sq_full = d_ff * d_ff;
   assign acc_sum = {1'b0, sum_ff} + (SUM_W + 1)'(sq_ff);

   // Scaled sum, halved, then clamped at 24.0
   assign prod_full = {p_hi_ff, {HALF_W{1'b0}}} + PROD_W'(p_lo_ff);
   assign a_val     = prod_full[PROD_W-1:1];
   assign a_sat     = a_val > EXP_LIMIT;

   // Series term and e^-1 step
   assign term_prod  = term_ff * f_ff;
   assign einv_prod  = tsum_ff * EINV_Q30;
   assign einv_round = {1'b0, einv_prod} + HALF_Q30;
   assign kv_round   = 32'(tsum_ff) + HALF_Q16;

   // Reciprocal of the term index, ceil(2^34 / i); exact floor divide for 30-bit terms
   always_comb begin
      unique case (cmd.term_idx)
         5'd1:    recip = 35'd17179869184;
         5'd2:    recip = 35'd8589934592;
         5'd3:    recip = 35'd5726623062;
         5'd4:    recip = 35'd4294967296;
         5'd5:    recip = 35'd3435973837;
         5'd6:    recip = 35'd2863311531;
         5'd7:    recip = 35'd2454267027;
         5'd8:    recip = 35'd2147483648;
         5'd9:    recip = 35'd1908874354;
         5'd10:   recip = 35'd1717986919;
         5'd11:   recip = 35'd1561806290;
         5'd12:   recip = 35'd1431655766;
         5'd13:   recip = 35'd1321528399;
         5'd14:   recip = 35'd1227133514;
         5'd15:   recip = 35'd1145324613;
         5'd16:   recip = 35'd1073741824;
         default: recip = '0;
      endcase
   end

   assign div_prod = dq_ff * recip;

   // Next-value logic
   always_comb begin
      sum_in  = sum_ff;
      inv_in  = inv_ff;
      d_in    = d_ff;
      last_in = last_ff;
      sq_in   = sq_ff;
      p_lo_in = p_lo_ff;
      p_hi_in = p_hi_ff;
      k_in    = k_ff;
      f_in    = f_ff;
      sat_in  = sat_ff;
      term_in = term_ff;
      tsum_in = tsum_ff;
      dq_in   = dq_ff;
      kv_in   = kv_ff;
      rsat_in = rsat_ff;

      if (csr_valid) begin
         inv_in = csr_data;
      end
      if (cmd.load_pair) begin
         d_in    = {req_data.x_coord[COORD_W-1], req_data.x_coord}
                 - {req_data.y_coord[COORD_W-1], req_data.y_coord};
         last_in = req_data.last_pair;
      end
      if (cmd.square) begin
         sq_in = sq_full[SQ_W-1:0];
      end
      if (cmd.accum) begin
         sum_in = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
      end
      if (cmd.prod_lo) begin
         p_lo_in = sum_ff[HALF_W-1:0] * inv_ff;
      end
      if (cmd.prod_hi) begin
         p_hi_in = sum_ff[SUM_W-1:HALF_W] * inv_ff;
      end
      if (cmd.exponent) begin
         sat_in  = a_sat;
         k_in    = a_sat ? K_LIMIT : a_val[F_W+K_W-1:F_W];
         f_in    = a_sat ? '0 : a_val[F_W-1:0];
         term_in = ONE_Q30;
         tsum_in = ONE_Q30;
         sum_in  = '0;
      end
      if (cmd.term_mul) begin
         dq_in = term_prod[DQ_W+F_W-1:F_W];
      end
      if (cmd.div_step) begin
         dq_in = div_prod[RECIP_SHIFT+DQ_W-1:RECIP_SHIFT];
      end
      if (cmd.term_add) begin
         term_in = TERM_W'(dq_ff);
         if (cmd.term_idx[0]) begin
            tsum_in = tsum_ff - TERM_W'(dq_ff);
         end else begin
            tsum_in = tsum_ff + TERM_W'(dq_ff);
         end
      end
      if (cmd.einv_step) begin
         tsum_in = einv_round[60:30];
         k_in    = k_ff - K_W'(1);
      end
      if (cmd.rsp_load) begin
         kv_in   = kv_round[KV_W+13:14];
         rsat_in = sat_ff;
      end
   end

   // Accumulator clear and inv_len_sq set to 1.0 at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         inv_ff <= INV_RESET;
      end else begin
         sum_ff <= sum_in;
         inv_ff <= inv_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      last_ff <= last_in;
      sq_ff   <= sq_in;
      p_lo_ff <= p_lo_in;
      p_hi_ff <= p_hi_in;
      k_ff    <= k_in;
      f_ff    <= f_in;
      sat_ff  <= sat_in;
      term_ff <= term_in;
      tsum_ff <= tsum_in;
      dq_ff   <= dq_in;
      kv_ff   <= kv_in;
      rsat_ff <= rsat_in;
   end

   // Status and result
   assign sts.last_pair = last_ff;
   assign sts.k_zero    = (k_ff == '0);

   assign rsp_data.kernel_value       = kv_ff;
   assign rsp_data.exponent_saturated = rsat_ff;

endmodule

// File: rtl/rbf_ctrl.sv
// Controller: sequences accumulate, scale, series, e^-1 steps and result transfer.
`timescale 1ns / 1ps

module rbf_ctrl
   import rbf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  rbf_sts_type  sts,
   output rbf_cmd_type  cmd
);

   rbf_state_type       state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TIDX_W-1:0]   term_idx_ff, term_idx_in;

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         term_idx_ff  <= TIDX_W'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         term_idx_ff  <= term_idx_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      term_idx_in  = term_idx_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.term_idx = term_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_pair = 1'b1;
               state_in      = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = sts.last_pair ? ST_PROD_LO : ST_IDLE;
         end
         ST_PROD_LO: begin
            cmd.prod_lo = 1'b1;
            state_in    = ST_PROD_HI;
         end
         ST_PROD_HI: begin
            cmd.prod_hi = 1'b1;
            state_in    = ST_EXPONENT;
         end
         ST_EXPONENT: begin
            cmd.exponent = 1'b1;
            term_idx_in  = TIDX_W'(1);
            state_in     = ST_TERM_MUL;
         end
         ST_TERM_MUL: begin
            cmd.term_mul = 1'b1;
            state_in     = ST_TERM_DIV;
         end
         ST_TERM_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = ST_TERM_ADD;
         end
         ST_TERM_ADD: begin
            cmd.term_add = 1'b1;
            if (term_idx_ff == TIDX_W'(TAYLOR_TERMS)) begin
               state_in = ST_EINV;
            end else begin
               term_idx_in = term_idx_ff + TIDX_W'(1);
               state_in    = ST_TERM_MUL;
            end
         end
         ST_EINV: begin
            if (sts.k_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.einv_step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register valid: set on load, cleared on transfer
   always_comb begin
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/rbf_kernel_evaluate_top.sv
// Gaussian RBF kernel evaluator, top level: exp(-0.5 * |x - y|^2 * inv_len_sq).
// Usage:
//   req_*  : one coordinate pair per transfer (x_coord, y_coord, signed Q8.8) with
//            last_pair set on the final pair of the two vectors.
//   rsp_*  : one result per last pair: kernel_value (Q1.16) and exponent_saturated.
//   csr_*  : write of inv_len_sq (Q8.16), always ready; write only while idle.
// Sequence:
//   A pair that is not last passes through difference, square and accumulate
//   steps; req_ready returns after the accumulate.
//   A last pair then takes two scale multiplies, the exponent split, the
//   series, k e^-1 multiplies (k the integer part of the clamped exponent,
//   0 to 24) and the result load. Each of the 16 series terms is one multiply,
//   one reciprocal multiply for the division by the term index and one add.
// Stalls:
//   The result sits in an output register. The next vector is accepted while it
//   waits; a later result holds the controller until rsp_ready frees the register.
// Reset:
//   Synchronous; clears the accumulator, sets inv_len_sq to 1.0, drops rsp_valid.
`timescale 1ns / 1ps

module rbf_kernel_evaluate_top
   import rbf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rbf_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rbf_rsp_type       rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [INV_W-1:0]  csr_data
);

   rbf_cmd_type cmd;
   rbf_sts_type sts;

   // Register write is taken in any cycle
   assign csr_ready = 1'b1;

   rbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rbf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/rbf_checker.sv
// Port-level checks of the kernel evaluator, bound to the top level.
`timescale 1ns / 1ps

module rbf_checker
   import rbf_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input rbf_req_type       req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rbf_rsp_type       rsp_data,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic [INV_W-1:0]  csr_data
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // No result is pending straight after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // A pair transfer keeps the input closed for the next cycle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted in back-to-back cycles");

   // A new result is loaded only while the input is closed
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while the input was open");

   // A clamped exponent always gives a zero kernel value
   a_sat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.exponent_saturated |-> rsp_data.kernel_value == '0)
      else $error("saturated exponent with non-zero kernel value");

endmodule

bind rbf_kernel_evaluate_top rbf_checker u_rbf_checker (.*);
